[hdl/assert_macros.svh]
// Assertion helper macros for the deque design.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check, clocked on clk and disabled while rst_n is low.
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication check: cons must hold whenever ante holds.
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check: cons must hold in the cycle after ante.
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
package deq_pkg;

    localparam int FUNC_W        = 3;
    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 8;
    localparam int STATUS_W      = 3;
    localparam int LENGTH_W      = 5;
    localparam int FUNC_TAIL_BIT = 2;

    typedef enum logic [1:0] {
        K_PUT    = 2'd0,
        K_GET    = 2'd1,
        K_INDEX  = 2'd2,
        K_REMOVE = 2'd3
    } t_dq_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_dq_status;

    // controller -> datapath
    typedef struct packed {
        logic       ld;        // latch request word
        logic       put;       // write word at chosen end, bump count
        logic       pop;       // drop element at chosen end
        logic       pos_init;  // load scan/read position for this request
        logic       pos_up;    // position + 1
        logic       pos_dn;    // position - 1
        logic       cap;       // capture read data as result
        logic       shift_wr;  // write read data one position toward head
        logic       dec_cnt;   // count - 1 after a remove
        logic       fin;       // latch result status
        t_dq_status st;
    } t_dq_cmd;

    // datapath -> controller
    typedef struct packed {
        t_dq_kind kind;
        logic     tail;
        logic     full;
        logic     empty;
        logic     idx_oor;
        logic     hit;        // read data equals request value
        logic     pos_first;  // position is the head element
        logic     pos_last;   // position is the tail element
    } t_dq_stat;

endpackage

[hdl/dq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/dq_ctrl.sv]
// Deque sequencer: decodes the latched request and steps put/get/read/remove.
// Depends on deq_pkg for command and status types.
module dq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  deq_pkg::t_dq_stat i_stat,
    output deq_pkg::t_dq_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state  r_state, n_state;
    logic    r_strobe, n_strobe;
    t_dq_cmd cmd;

    always_comb begin
        cmd      = '0;
        cmd.st   = ST_OK;
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.ld  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.kind)
                    K_PUT: begin
                        cmd.fin = 1'b1;
                        if (i_stat.full) begin
                            cmd.st = ST_FULL;
                        end else begin
                            cmd.put = 1'b1;
                        end
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                    K_GET: begin
                        if (i_stat.empty) begin
                            cmd.fin  = 1'b1;
                            cmd.st   = ST_EMPTY;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            cmd.pos_init = 1'b1;
                            cmd.pop      = 1'b1;
                            n_state      = S_READ;
                        end
                    end
                    K_INDEX: begin
                        if (i_stat.idx_oor) begin
                            cmd.fin  = 1'b1;
                            cmd.st   = ST_RANGE;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            cmd.pos_init = 1'b1;
                            n_state      = S_READ;
                        end
                    end
                    K_REMOVE: begin
                        if (i_stat.empty) begin
                            cmd.fin  = 1'b1;
                            cmd.st   = ST_EMPTY;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            cmd.pos_init = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                cmd.cap  = 1'b1;
                cmd.fin  = 1'b1;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    cmd.cap = 1'b1;
                    if (i_stat.pos_last) begin
                        // match at the tail element: nothing to close up
                        cmd.dec_cnt = 1'b1;
                        cmd.fin     = 1'b1;
                        n_strobe    = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        // fetch the word behind the match to start compaction
                        cmd.pos_up = 1'b1;
                        n_state    = S_SHIFT;
                    end
                end else if (i_stat.tail ? i_stat.pos_first : i_stat.pos_last) begin
                    cmd.fin  = 1'b1;
                    cmd.st   = ST_NOTFOUND;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_stat.tail) begin
                    cmd.pos_dn = 1'b1;
                end else begin
                    cmd.pos_up = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.shift_wr = 1'b1;
                if (i_stat.pos_last) begin
                    cmd.dec_cnt = 1'b1;
                    cmd.fin     = 1'b1;
                    n_strobe    = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    cmd.pos_up = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

[hdl/dq_dp.sv]
// Deque datapath: head/count registers, position counter, element RAM, compare.
// Depends on deq_pkg and dq_ram.
module dq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_dq_cmd               i_cmd,
    input  logic [deq_pkg::FUNC_W-1:0]     i_func,
    input  logic [deq_pkg::VALUE_W-1:0]    i_value,
    input  logic [deq_pkg::INDEX_W-1:0]    i_index,
    output deq_pkg::t_dq_stat              o_stat,
    output logic [deq_pkg::VALUE_W-1:0]    o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]   o_status,
    output logic [deq_pkg::LENGTH_W-1:0]   o_length
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [AW:0]   DEPTH_X   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    logic [FUNC_W-1:0]     r_func;
    logic [DATA_WIDTH-1:0] r_value;
    logic [INDEX_W-1:0]    r_index;
    logic [DATA_WIDTH-1:0] r_rval;
    t_dq_status            r_status;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;

    logic [63:0]           value_x;
    logic [63:0]           rval_x;
    logic [63:0]           len_x;
    logic                  tail;
    t_dq_kind              kind;
    logic [CW-1:0]         cnt_m1_w;
    logic [AW-1:0]         cnt_m1;
    logic [XW-1:0]         tidx_w;
    logic [XW-1:0]         idx_w;
    logic [AW-1:0]         head_m1;
    logic [AW-1:0]         head_p1;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    assign value_x  = 64'(i_value);
    assign tail     = r_func[FUNC_TAIL_BIT];
    assign kind     = t_dq_kind'(r_func[1:0]);
    assign cnt_m1_w = r_count - CW'(1);
    assign cnt_m1   = cnt_m1_w[AW-1:0];
    assign idx_w    = XW'(r_index);
    assign tidx_w   = XW'(r_count) - XW'(1) - idx_w;
    assign head_m1  = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign head_p1  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);

    // position of the word whose read is issued this cycle
    always_comb begin
        n_pos = r_pos;
        if (i_cmd.pos_init) begin
            if (kind == K_INDEX) begin
                n_pos = tail ? tidx_w[AW-1:0] : idx_w[AW-1:0];
            end else begin
                n_pos = tail ? cnt_m1 : '0;
            end
        end else if (i_cmd.pos_up) begin
            n_pos = r_pos + AW'(1);
        end else if (i_cmd.pos_dn) begin
            n_pos = r_pos - AW'(1);
        end
    end

    assign raddr = slot_of(r_head, n_pos);
    assign we    = i_cmd.put | i_cmd.shift_wr;
    assign wdata = i_cmd.put ? r_value : rdata;

    always_comb begin
        if (i_cmd.put) begin
            waddr = tail ? slot_of(r_head, r_count[AW-1:0]) : head_m1;
        end else begin
            waddr = slot_of(r_head, r_pos - AW'(1));
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_func  <= i_func;
            r_value <= value_x[DATA_WIDTH-1:0];
            r_index <= i_index;
            r_rval  <= '0;
        end else if (i_cmd.cap) begin
            r_rval <= rdata;
        end
        if (i_cmd.fin) begin
            r_status <= i_cmd.st;
        end
        r_pos <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
                if (!tail) begin
                    r_head <= head_m1;
                end
            end else if (i_cmd.pop) begin
                r_count <= cnt_m1_w;
                if (!tail) begin
                    r_head <= head_p1;
                end
            end else if (i_cmd.dec_cnt) begin
                r_count <= cnt_m1_w;
            end
        end
    end

    assign o_stat.kind      = kind;
    assign o_stat.tail      = tail;
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.idx_oor   = (idx_w >= XW'(r_count));
    assign o_stat.hit       = (rdata == r_value);
    assign o_stat.pos_first = (r_pos == '0);
    assign o_stat.pos_last  = (CW'(r_pos) == cnt_m1_w);

    assign rval_x         = 64'(r_rval);
    assign len_x          = 64'(r_count);
    assign o_result_value = rval_x[VALUE_W-1:0];
    assign o_status       = r_status;
    assign o_length       = len_x[LENGTH_W-1:0];

endmodule

[hdl/double_ended_queue.sv]
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on deq_pkg, dq_ctrl, dq_dp (with dq_ram) and assert_macros.svh.
//
// Usage:
//  - A request (i_func, i_value, i_index) is taken at a clock edge with start
//    high and busy low. busy stays high until the request's result is shown.
//  - Exactly one result per request: o_result_value, o_status, o_length are
//    valid for the single cycle in which o_strobe is high. There is no
//    backpressure; the receiver must take the word in that cycle.
//  - From the accepting edge, put and a request refused at decode (full,
//    empty, index out of range) finish in decode; get and indexed read
//    then go through the read state. Remove compares entries in turn and
//    then moves the entries behind a match toward the head to close the
//    gap; a remove that finds nothing compares every entry.
//    The scan and compaction walk the element RAM one word per cycle
//    through its single read and write port.
//  - busy drops in the strobe cycle, so the next request can be taken there.
//  - Synchronous active-low reset empties the queue (head 0, length 0);
//    the element RAM is not cleared and needs no sweep.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [deq_pkg::FUNC_W-1:0]   i_func,
    input  logic [deq_pkg::VALUE_W-1:0]  i_value,
    input  logic [deq_pkg::INDEX_W-1:0]  i_index,
    output logic                         o_strobe,
    output logic [deq_pkg::VALUE_W-1:0]  o_result_value,
    output logic [deq_pkg::STATUS_W-1:0] o_status,
    output logic [deq_pkg::LENGTH_W-1:0] o_length
);
    import deq_pkg::*;

    t_dq_cmd  cmd;
    t_dq_stat stat;

    dq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    dq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_index        (i_index),
        .o_stat         (stat),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_length       (o_length)
    );

    // every request passes through decode before its result
    `DQ_ASSERT_NXT(a_accept_no_strobe, i_clk, i_rst_n, start && !busy, busy && !o_strobe,
        "strobe right after accept")
    `DQ_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe,
        "strobe held two cycles")
    `DQ_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy,
        "busy during result word")
    `DQ_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_strobe && (o_status != ST_OK),
        o_result_value == '0, "failed request returned data")

endmodule
